@@ hw/rtl/psg_pkg.sv @@
// shared types, widths, codes and reset values of the proximity speed governor
package psg_pkg;

   localparam int DIST_W     = 16;
   localparam int SPEED_W    = 12;
   localparam int MISS_W     = 8;
   localparam int WIN_W      = 11;
   localparam int FUNC_W     = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = SPEED_W + DIST_W;
   localparam int STEP_W     = $clog2(SPEED_W);

   localparam int DEF_MAX_SCAN_SAMPLES = 1024;

   localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE = 16'd1400;
   localparam logic [DIST_W-1:0]  RST_SLOW_DISTANCE = 16'd1800;
   localparam logic [MISS_W-1:0]  RST_MISS_LIMIT    = 8'd5;
   localparam logic [WIN_W-1:0]   RST_FRONT_COUNT   = 11'd30;
   localparam logic [WIN_W-1:0]   RST_REAR_START    = 11'd330;
   localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED  = 12'd200;
   localparam logic [DIST_W-1:0]  DIST_INFINITE     = 16'hFFFF;
   localparam logic [MISS_W-1:0]  MISS_SATURATE     = 8'hFF;

   localparam logic [CSR_ADDR_W-1:0] CSR_STOP_DISTANCE = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_SLOW_DISTANCE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_MISS_LIMIT    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_FRONT_COUNT   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_REAR_START    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_CRUISE_SPEED  = 3'd5;

   localparam logic [FUNC_W-1:0] FUNC_ALERT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_RAMP
   } psg_state_type;

   typedef enum logic [1:0] {
      RAMP_IDLE,
      RAMP_MUL,
      RAMP_DIV
   } psg_ramp_phase_type;

   typedef struct packed {
      logic               start;
      logic [SPEED_W-1:0] cruise;
      logic [DIST_W-1:0]  diff;
      logic [DIST_W-1:0]  den;
   } psg_ramp_req_type;

   typedef struct packed {
      logic               done;
      logic [SPEED_W-1:0] quotient;
   } psg_ramp_rsp_type;

endpackage

@@ hw/rtl/psg_ramp.sv @@
// bit-serial multiply then restoring divide for the speed ramp
module psg_ramp (
   input  logic                      clock,
   input  logic                      reset,
   input  psg_pkg::psg_ramp_req_type ramp_req,
   output psg_pkg::psg_ramp_rsp_type ramp_rsp
);

   psg_pkg::psg_ramp_phase_type phase_ff, phase_in;

   logic [psg_pkg::PROD_W-1:0]  acc_ff, acc_in;
   logic [psg_pkg::SPEED_W-1:0] mplier_ff, mplier_in;
   logic [psg_pkg::DIST_W-1:0]  diff_ff, diff_in;
   logic [psg_pkg::DIST_W-1:0]  den_ff, den_in;
   logic [psg_pkg::DIST_W-1:0]  rem_ff, rem_in;
   logic [psg_pkg::SPEED_W-1:0] quo_ff, quo_in;
   logic [psg_pkg::STEP_W-1:0]  step_ff, step_in;

   logic [psg_pkg::PROD_W-1:0]  mul_sum;
   logic [psg_pkg::DIST_W:0]    part;
   logic [psg_pkg::DIST_W:0]    part_sub;
   logic                        part_ge;
   logic                        last_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= psg_pkg::RAMP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mplier_ff <= mplier_in;
      diff_ff   <= diff_in;
      den_ff    <= den_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
   end

   always_comb begin
      mul_sum   = {acc_ff[psg_pkg::PROD_W-2:0], 1'b0}
                + (mplier_ff[psg_pkg::SPEED_W-1] ? psg_pkg::PROD_W'(diff_ff)
                                                 : {psg_pkg::PROD_W{1'b0}});
      part      = {rem_ff, quo_ff[psg_pkg::SPEED_W-1]};
      part_sub  = part - {1'b0, den_ff};
      part_ge   = (part >= {1'b0, den_ff});
      last_step = (step_ff == psg_pkg::STEP_W'(psg_pkg::SPEED_W - 1));

      phase_in  = phase_ff;
      acc_in    = acc_ff;
      mplier_in = mplier_ff;
      diff_in   = diff_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      ramp_rsp.done     = 1'b0;
      ramp_rsp.quotient = quo_ff;

      case (phase_ff)
         psg_pkg::RAMP_IDLE: begin
            if (ramp_req.start) begin
               acc_in    = '0;
               mplier_in = ramp_req.cruise;
               diff_in   = ramp_req.diff;
               den_in    = ramp_req.den;
               step_in   = '0;
               phase_in  = psg_pkg::RAMP_MUL;
            end
         end
         psg_pkg::RAMP_MUL: begin
            acc_in    = mul_sum;
            mplier_in = {mplier_ff[psg_pkg::SPEED_W-2:0], 1'b0};
            step_in   = step_ff + 1'b1;
            if (last_step) begin
               // high part is below the divisor since the quotient fits in speed width
               rem_in   = mul_sum[psg_pkg::PROD_W-1:psg_pkg::SPEED_W];
               quo_in   = mul_sum[psg_pkg::SPEED_W-1:0];
               step_in  = '0;
               phase_in = psg_pkg::RAMP_DIV;
            end
         end
         psg_pkg::RAMP_DIV: begin
            rem_in  = part_ge ? part_sub[psg_pkg::DIST_W-1:0] : part[psg_pkg::DIST_W-1:0];
            quo_in  = {quo_ff[psg_pkg::SPEED_W-2:0], part_ge};
            step_in = step_ff + 1'b1;
            if (last_step) begin
               ramp_rsp.done     = 1'b1;
               ramp_rsp.quotient = quo_in;
               phase_in          = psg_pkg::RAMP_IDLE;
            end
         end
         default: begin
            phase_in = psg_pkg::RAMP_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/proximity_speed_governor_top.sv @@
// proximity speed governor top level
// alert and scan sample transfers give no result
// a tick that needs no ramp shows its result in the cycle after the transfer
// a ramp tick runs 12 multiply and 12 divide steps in psg_ramp before its result is registered
// input stalls while the ramp runs or a result waits, so no new tick is taken until the ramp is done
// synchronous active-high reset: registers to defaults, distances to infinity, no result
module proximity_speed_governor_top #(
   parameter int MAX_SCAN_SAMPLES = psg_pkg::DEF_MAX_SCAN_SAMPLES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [psg_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [psg_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [psg_pkg::FUNC_W-1:0]       req_func,
   input  logic                             req_target_seen,
   input  logic [psg_pkg::DIST_W-1:0]       req_range_mm,
   input  logic                             req_range_invalid,
   input  logic [psg_pkg::DIST_W-1:0]       req_range_max_mm,
   input  logic                             req_last_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [psg_pkg::SPEED_W-1:0]      rsp_speed_mm_s,
   output logic                             rsp_visible_flag,
   output logic [psg_pkg::DIST_W-1:0]       rsp_front_distance_out
);

   localparam int IDX_W = $clog2(MAX_SCAN_SAMPLES + 1);
   localparam int CMP_W = (IDX_W > psg_pkg::WIN_W) ? IDX_W : psg_pkg::WIN_W;

   logic [psg_pkg::DIST_W-1:0]  stop_distance_ff;
   logic [psg_pkg::DIST_W-1:0]  slow_distance_ff;
   logic [psg_pkg::MISS_W-1:0]  miss_limit_ff;
   logic [psg_pkg::WIN_W-1:0]   front_count_ff;
   logic [psg_pkg::WIN_W-1:0]   rear_start_ff;
   logic [psg_pkg::SPEED_W-1:0] cruise_speed_ff;

   psg_pkg::psg_state_type state_ff, state_in;

   logic                        target_visible_ff, target_visible_in;
   logic [psg_pkg::MISS_W-1:0]  miss_count_ff, miss_count_in;
   logic [IDX_W-1:0]            sample_index_ff, sample_index_in;
   logic [psg_pkg::DIST_W-1:0]  running_min_ff, running_min_in;
   logic                        window_hit_ff, window_hit_in;
   logic [psg_pkg::DIST_W-1:0]  front_distance_ff, front_distance_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [psg_pkg::SPEED_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic                        rsp_visible_ff, rsp_visible_in;
   logic [psg_pkg::DIST_W-1:0]  rsp_front_ff, rsp_front_in;

   psg_pkg::psg_ramp_req_type ramp_req;
   psg_pkg::psg_ramp_rsp_type ramp_rsp;

   logic                        req_fire;
   logic                        rsp_free;
   logic [psg_pkg::MISS_W-1:0]  miss_inc;
   logic [psg_pkg::DIST_W-1:0]  sample_range;
   logic [CMP_W-1:0]            idx_ext;
   logic                        idx_live;
   logic                        in_window;
   logic [psg_pkg::DIST_W-1:0]  min_new;
   logic                        hit_new;

   psg_ramp u_psg_ramp (
      .clock    (clock),
      .reset    (reset),
      .ramp_req (ramp_req),
      .ramp_rsp (ramp_rsp)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stop_distance_ff <= psg_pkg::RST_STOP_DISTANCE;
         slow_distance_ff <= psg_pkg::RST_SLOW_DISTANCE;
         miss_limit_ff    <= psg_pkg::RST_MISS_LIMIT;
         front_count_ff   <= psg_pkg::RST_FRONT_COUNT;
         rear_start_ff    <= psg_pkg::RST_REAR_START;
         cruise_speed_ff  <= psg_pkg::RST_CRUISE_SPEED;
      end else if (csr_wr_en) begin
         case (csr_addr)
            psg_pkg::CSR_STOP_DISTANCE: stop_distance_ff <= csr_wdata[psg_pkg::DIST_W-1:0];
            psg_pkg::CSR_SLOW_DISTANCE: slow_distance_ff <= csr_wdata[psg_pkg::DIST_W-1:0];
            psg_pkg::CSR_MISS_LIMIT:    miss_limit_ff    <= csr_wdata[psg_pkg::MISS_W-1:0];
            psg_pkg::CSR_FRONT_COUNT:   front_count_ff   <= csr_wdata[psg_pkg::WIN_W-1:0];
            psg_pkg::CSR_REAR_START:    rear_start_ff    <= csr_wdata[psg_pkg::WIN_W-1:0];
            psg_pkg::CSR_CRUISE_SPEED:  cruise_speed_ff  <= csr_wdata[psg_pkg::SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= psg_pkg::ST_IDLE;
         target_visible_ff <= 1'b0;
         miss_count_ff     <= '0;
         sample_index_ff   <= '0;
         running_min_ff    <= psg_pkg::DIST_INFINITE;
         window_hit_ff     <= 1'b0;
         front_distance_ff <= psg_pkg::DIST_INFINITE;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         target_visible_ff <= target_visible_in;
         miss_count_ff     <= miss_count_in;
         sample_index_ff   <= sample_index_in;
         running_min_ff    <= running_min_in;
         window_hit_ff     <= window_hit_in;
         front_distance_ff <= front_distance_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_speed_ff   <= rsp_speed_in;
      rsp_visible_ff <= rsp_visible_in;
      rsp_front_ff   <= rsp_front_in;
   end

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != psg_pkg::ST_IDLE) || !rsp_free;
   assign req_fire  = req_valid && !req_stall;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_speed_mm_s         = rsp_speed_ff;
   assign rsp_visible_flag       = rsp_visible_ff;
   assign rsp_front_distance_out = rsp_front_ff;

   always_comb begin
      miss_inc     = (miss_count_ff == psg_pkg::MISS_SATURATE) ? miss_count_ff
                                                               : miss_count_ff + 1'b1;
      sample_range = req_range_invalid ? req_range_max_mm : req_range_mm;
      idx_ext      = CMP_W'(sample_index_ff);
      idx_live     = (sample_index_ff < IDX_W'(MAX_SCAN_SAMPLES));
      in_window    = idx_live && ((idx_ext < CMP_W'(front_count_ff))
                               || (idx_ext >= CMP_W'(rear_start_ff)));
      min_new      = (in_window && (sample_range < running_min_ff)) ? sample_range
                                                                    : running_min_ff;
      hit_new      = window_hit_ff || in_window;

      state_in          = state_ff;
      target_visible_in = target_visible_ff;
      miss_count_in     = miss_count_ff;
      sample_index_in   = sample_index_ff;
      running_min_in    = running_min_ff;
      window_hit_in     = window_hit_ff;
      front_distance_in = front_distance_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_speed_in   = rsp_speed_ff;
      rsp_visible_in = rsp_visible_ff;
      rsp_front_in   = rsp_front_ff;

      ramp_req.start  = 1'b0;
      ramp_req.cruise = cruise_speed_ff;
      ramp_req.diff   = front_distance_ff - stop_distance_ff;
      ramp_req.den    = slow_distance_ff - stop_distance_ff;

      case (state_ff)
         psg_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_func)
                  psg_pkg::FUNC_ALERT: begin
                     if (req_target_seen) begin
                        target_visible_in = 1'b1;
                        miss_count_in     = '0;
                     end else begin
                        miss_count_in = miss_inc;
                        if (miss_inc >= miss_limit_ff) begin
                           target_visible_in = 1'b0;
                        end
                     end
                  end
                  psg_pkg::FUNC_SAMPLE: begin
                     if (req_last_sample) begin
                        front_distance_in = hit_new ? min_new : req_range_max_mm;
                        sample_index_in   = '0;
                        running_min_in    = psg_pkg::DIST_INFINITE;
                        window_hit_in     = 1'b0;
                     end else begin
                        running_min_in = min_new;
                        window_hit_in  = hit_new;
                        if (idx_live) begin
                           sample_index_in = sample_index_ff + 1'b1;
                        end
                     end
                  end
                  psg_pkg::FUNC_TICK: begin
                     rsp_visible_in = target_visible_ff;
                     rsp_front_in   = front_distance_ff;
                     if (!target_visible_ff || (front_distance_ff > slow_distance_ff)) begin
                        rsp_valid_in = 1'b1;
                        rsp_speed_in = cruise_speed_ff;
                     end else if (front_distance_ff > stop_distance_ff) begin
                        ramp_req.start = 1'b1;
                        state_in       = psg_pkg::ST_RAMP;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_speed_in = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         psg_pkg::ST_RAMP: begin
            if (ramp_rsp.done) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = ramp_rsp.quotient;
               state_in     = psg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = psg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/psg_checker.sv @@
// port-level checker for the proximity speed governor and its bind
module psg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [psg_pkg::FUNC_W-1:0]   req_func,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [psg_pkg::SPEED_W-1:0]  rsp_speed_mm_s,
   input logic                         rsp_visible_flag,
   input logic [psg_pkg::DIST_W-1:0]   rsp_front_distance_out
);

   // reset leaves no result and an open input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("result or stall after reset");

   // a tick transfer either yields a result or holds the input while the ramp runs
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == psg_pkg::FUNC_TICK))
      |=> (rsp_valid || req_stall))
      else $error("tick transfer left no trace");

   // alerts and samples never create a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func != psg_pkg::FUNC_TICK) && !rsp_valid)
      |=> !rsp_valid)
      else $error("result without a tick");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_speed_mm_s) && $stable(rsp_visible_flag)
                                    && $stable(rsp_front_distance_out)))
      else $error("stalled result changed");

endmodule

bind proximity_speed_governor_top psg_checker u_psg_checker (.*);

@@ test/proximity_speed_governor_top_test.sv @@
// testbench of the proximity speed governor: directed and random items checked against a predictor
`timescale 1ns / 100ps

module proximity_speed_governor_top_test;

   localparam logic [psg_pkg::FUNC_W-1:0]     FUNC_UNUSED     = 2'd3;
   localparam logic [psg_pkg::CSR_ADDR_W-1:0] CSR_UNUSED_LO   = 3'd6;
   localparam logic [psg_pkg::CSR_ADDR_W-1:0] CSR_UNUSED_HI   = 3'd7;
   localparam int                             SETTLE_CYCLES   = 30;
   localparam int                             HOLD_OFF_CYCLES = 300;
   localparam int                             WATCHDOG_LIMIT  = 2000;

   typedef struct packed {
      logic [psg_pkg::FUNC_W-1:0] func;
      logic                       target_seen;
      logic [psg_pkg::DIST_W-1:0] range_mm;
      logic                       range_invalid;
      logic [psg_pkg::DIST_W-1:0] range_max_mm;
      logic                       last_sample;
   } governor_item_type;

   typedef struct packed {
      logic [psg_pkg::SPEED_W-1:0] speed;
      logic                        visible;
      logic [psg_pkg::DIST_W-1:0]  front_mm;
   } speed_command_type;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [psg_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [psg_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                           req_valid;
   logic                           req_stall;
   logic [psg_pkg::FUNC_W-1:0]     req_func;
   logic                           req_target_seen;
   logic [psg_pkg::DIST_W-1:0]     req_range_mm;
   logic                           req_range_invalid;
   logic [psg_pkg::DIST_W-1:0]     req_range_max_mm;
   logic                           req_last_sample;
   logic                           rsp_valid;
   logic                           rsp_stall;
   logic [psg_pkg::SPEED_W-1:0]    rsp_speed_mm_s;
   logic                           rsp_visible_flag;
   logic [psg_pkg::DIST_W-1:0]     rsp_front_distance_out;

   // register copies
   logic [psg_pkg::DIST_W-1:0]  cfg_stop_mm     = psg_pkg::RST_STOP_DISTANCE;
   logic [psg_pkg::DIST_W-1:0]  cfg_slow_mm     = psg_pkg::RST_SLOW_DISTANCE;
   logic [psg_pkg::MISS_W-1:0]  cfg_miss_limit  = psg_pkg::RST_MISS_LIMIT;
   logic [psg_pkg::WIN_W-1:0]   cfg_front_count = psg_pkg::RST_FRONT_COUNT;
   logic [psg_pkg::WIN_W-1:0]   cfg_rear_start  = psg_pkg::RST_REAR_START;
   logic [psg_pkg::SPEED_W-1:0] cfg_cruise      = psg_pkg::RST_CRUISE_SPEED;

   // governor state as predicted
   logic                       gov_visible    = 1'b0;
   logic [psg_pkg::MISS_W-1:0] gov_misses     = '0;
   logic [psg_pkg::WIN_W-1:0]  gov_scan_index = '0;
   logic [psg_pkg::DIST_W-1:0] gov_scan_min   = psg_pkg::DIST_INFINITE;
   logic                       gov_scan_hit   = 1'b0;
   logic [psg_pkg::DIST_W-1:0] gov_front_mm   = psg_pkg::DIST_INFINITE;

   speed_command_type pending_commands[$];
   int                error_count   = 0;
   int                quiet_cycles  = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                rsp_hold_left = 0;

   proximity_speed_governor_top dut (
      .clock                  (clock),
      .reset                  (reset),
      .csr_wr_en              (csr_wr_en),
      .csr_addr               (csr_addr),
      .csr_wdata              (csr_wdata),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_func               (req_func),
      .req_target_seen        (req_target_seen),
      .req_range_mm           (req_range_mm),
      .req_range_invalid      (req_range_invalid),
      .req_range_max_mm       (req_range_max_mm),
      .req_last_sample        (req_last_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_speed_mm_s         (rsp_speed_mm_s),
      .rsp_visible_flag       (rsp_visible_flag),
      .rsp_front_distance_out (rsp_front_distance_out)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic predict_governor(input governor_item_type it);
      logic [psg_pkg::DIST_W-1:0] sample_mm;
      int unsigned                fd, stp, slw, spd;
      speed_command_type          cmd;
      case (it.func)
         psg_pkg::FUNC_ALERT: begin
            if (it.target_seen) begin
               gov_visible = 1'b1;
               gov_misses  = '0;
            end else begin
               if (gov_misses != psg_pkg::MISS_SATURATE) gov_misses++;
               if (gov_misses >= cfg_miss_limit) gov_visible = 1'b0;
            end
         end
         psg_pkg::FUNC_SAMPLE: begin
            sample_mm = it.range_invalid ? it.range_max_mm : it.range_mm;
            if (32'(gov_scan_index) < psg_pkg::DEF_MAX_SCAN_SAMPLES) begin
               if (gov_scan_index < cfg_front_count || gov_scan_index >= cfg_rear_start) begin
                  if (sample_mm < gov_scan_min) gov_scan_min = sample_mm;
                  gov_scan_hit = 1'b1;
               end
               gov_scan_index++;
            end
            if (it.last_sample) begin
               gov_front_mm   = gov_scan_hit ? gov_scan_min : it.range_max_mm;
               gov_scan_index = '0;
               gov_scan_min   = psg_pkg::DIST_INFINITE;
               gov_scan_hit   = 1'b0;
            end
         end
         psg_pkg::FUNC_TICK: begin
            fd  = 32'(gov_front_mm);
            stp = 32'(cfg_stop_mm);
            slw = 32'(cfg_slow_mm);
            if (!gov_visible || fd > slw) spd = 32'(cfg_cruise);
            else if (fd > stp) spd = (32'(cfg_cruise) * (fd - stp)) / (slw - stp);
            else spd = 0;
            cmd.speed        = psg_pkg::SPEED_W'(spd);
            cmd.visible      = gov_visible;
            cmd.front_mm     = gov_front_mm;
            pending_commands = {pending_commands, cmd};
         end
         default: ;
      endcase
   endtask

   function automatic governor_item_type item_of(input logic [psg_pkg::FUNC_W-1:0] func);
      governor_item_type it;
      it.func          = func;
      it.target_seen   = 1'($urandom_range(1));
      it.range_mm      = psg_pkg::DIST_W'($urandom_range(16'hFFFF));
      it.range_invalid = 1'($urandom_range(1));
      it.range_max_mm  = psg_pkg::DIST_W'($urandom_range(16'hFFFF));
      it.last_sample   = 1'($urandom_range(1));
      return it;
   endfunction

   // distances mostly cluster around the stop and slow thresholds, with zero, infinity and uniform picks mixed in
   function automatic logic [psg_pkg::DIST_W-1:0] pick_distance();
      int unsigned lo, hi;
      lo = 32'((cfg_stop_mm < cfg_slow_mm) ? cfg_stop_mm : cfg_slow_mm);
      hi = 32'((cfg_stop_mm < cfg_slow_mm) ? cfg_slow_mm : cfg_stop_mm);
      case ($urandom_range(9))
         0: return '0;
         1: return psg_pkg::DIST_INFINITE;
         2, 3: return psg_pkg::DIST_W'($urandom_range(16'hFFFF));
         4: return ($urandom_range(1) != 0)
                   ? cfg_stop_mm + psg_pkg::DIST_W'($urandom_range(1))
                   : cfg_slow_mm + psg_pkg::DIST_W'($urandom_range(1));
         default: begin
            lo = (lo > 64) ? lo - 64 : 0;
            hi = (hi + 64 > 65535) ? 65535 : hi + 64;
            return psg_pkg::DIST_W'($urandom_range(hi, lo));
         end
      endcase
   endfunction

   task automatic send_item(input governor_item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_func          <= it.func;
      req_target_seen   <= it.target_seen;
      req_range_mm      <= it.range_mm;
      req_range_invalid <= it.range_invalid;
      req_range_max_mm  <= it.range_max_mm;
      req_last_sample   <= it.last_sample;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_governor(it);
   endtask

   task automatic send_alert(input logic seen);
      governor_item_type it;
      it = item_of(psg_pkg::FUNC_ALERT);
      it.target_seen = seen;
      send_item(it);
   endtask

   task automatic send_sample(input logic [psg_pkg::DIST_W-1:0] range_val,
                              input logic invalid,
                              input logic [psg_pkg::DIST_W-1:0] max_val, input logic last);
      governor_item_type it;
      it = item_of(psg_pkg::FUNC_SAMPLE);
      it.range_mm      = range_val;
      it.range_invalid = invalid;
      it.range_max_mm  = max_val;
      it.last_sample   = last;
      send_item(it);
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_commands.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce_block();
      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [psg_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [psg_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (addr)
         psg_pkg::CSR_STOP_DISTANCE: cfg_stop_mm     = value;
         psg_pkg::CSR_SLOW_DISTANCE: cfg_slow_mm     = value;
         psg_pkg::CSR_MISS_LIMIT:    cfg_miss_limit  = psg_pkg::MISS_W'(value);
         psg_pkg::CSR_FRONT_COUNT:   cfg_front_count = psg_pkg::WIN_W'(value);
         psg_pkg::CSR_REAR_START:    cfg_rear_start  = psg_pkg::WIN_W'(value);
         psg_pkg::CSR_CRUISE_SPEED:  cfg_cruise      = psg_pkg::SPEED_W'(value);
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] stop, input logic [15:0] slow,
                            input logic [15:0] miss, input logic [15:0] front,
                            input logic [15:0] rear, input logic [15:0] cruise);
      quiesce_block();
      write_register(psg_pkg::CSR_STOP_DISTANCE, stop);
      write_register(psg_pkg::CSR_SLOW_DISTANCE, slow);
      write_register(psg_pkg::CSR_MISS_LIMIT, miss);
      write_register(psg_pkg::CSR_FRONT_COUNT, front);
      write_register(psg_pkg::CSR_REAR_START, rear);
      write_register(psg_pkg::CSR_CRUISE_SPEED, cruise);
   endtask

   task automatic run_random_traffic(input int unsigned item_budget);
      int unsigned       sent;
      int unsigned       len;
      int unsigned       pick;
      governor_item_type it;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(80, 30) : $urandom_range(12, 1);
            for (int unsigned k = 0; k < len; k++) begin
               send_sample(pick_distance(), ($urandom_range(7) == 0), pick_distance(),
                           (k == len - 1));
               if ($urandom_range(9) == 0) begin
                  send_item(item_of(psg_pkg::FUNC_TICK));
                  sent++;
               end
            end
            sent += len;
         end else if (pick < 60) begin
            len = $urandom_range(6, 1);
            for (int unsigned k = 0; k < len; k++)
               send_alert((k == 0) ? ($urandom_range(1) != 0) : ($urandom_range(4) == 0));
            sent += len;
         end else if (pick < 92) begin
            send_item(item_of(psg_pkg::FUNC_TICK));
            sent++;
         end else begin
            // arbitrary content, broken scans and the unused kind
            it = item_of(psg_pkg::FUNC_W'($urandom_range(3)));
            send_item(it);
            if (it.func != FUNC_UNUSED) sent++;
         end
      end
   endtask

   task automatic test_visibility_tracking();
      send_item(item_of(psg_pkg::FUNC_TICK));
      send_alert(1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
      repeat (4) send_alert(1'b0);
      send_item(item_of(psg_pkg::FUNC_TICK));
      send_alert(1'b0);
      send_item(item_of(psg_pkg::FUNC_TICK));
      // a zero miss limit drops the target on the first miss
      quiesce_block();
      write_register(psg_pkg::CSR_MISS_LIMIT, 16'd0);
      send_alert(1'b1);
      send_alert(1'b0);
      send_item(item_of(psg_pkg::FUNC_TICK));
   endtask

   task automatic test_front_sector_and_ramp();
      configure(psg_pkg::RST_STOP_DISTANCE, psg_pkg::RST_SLOW_DISTANCE,
                psg_pkg::CSR_DATA_W'(psg_pkg::RST_MISS_LIMIT),
                psg_pkg::CSR_DATA_W'(psg_pkg::RST_FRONT_COUNT),
                psg_pkg::CSR_DATA_W'(psg_pkg::RST_REAR_START),
                psg_pkg::CSR_DATA_W'(psg_pkg::RST_CRUISE_SPEED));
      send_alert(1'b1);
      send_sample(16'd1700, 1'b0, 16'd0, 1'b0);
      send_sample(16'd0, 1'b1, 16'd1600, 1'b0);
      send_sample(16'hFFFF, 1'b0, 16'd0, 1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
      // empty window commits the maximum range
      quiesce_block();
      write_register(psg_pkg::CSR_FRONT_COUNT, 16'd0);
      send_sample(16'd10, 1'b0, 16'd1500, 1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
      send_sample(16'd0, 1'b0, 16'd1400, 1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
   endtask

   task automatic test_slow_below_stop();
      quiesce_block();
      write_register(psg_pkg::CSR_STOP_DISTANCE, 16'd2000);
      write_register(psg_pkg::CSR_SLOW_DISTANCE, 16'd1000);
      send_sample(16'd5, 1'b0, 16'd1500, 1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
      send_sample(16'd5, 1'b0, 16'd900, 1'b1);
      send_item(item_of(psg_pkg::FUNC_TICK));
   endtask

   task automatic test_unused_codes();
      send_item(item_of(FUNC_UNUSED));
      send_item(item_of(psg_pkg::FUNC_TICK));
      quiesce_block();
      write_register(CSR_UNUSED_LO, psg_pkg::CSR_DATA_W'($urandom_range(16'hFFFF)));
      write_register(CSR_UNUSED_HI, psg_pkg::CSR_DATA_W'($urandom_range(16'hFFFF)));
      send_item(item_of(psg_pkg::FUNC_TICK));
   endtask

   task automatic test_random_moderate();
      logic [15:0] stop;
      stop = 16'($urandom_range(3000, 200));
      configure(stop, stop + 16'($urandom_range(1500, 1)), 16'($urandom_range(6, 1)),
                16'($urandom_range(6)), 16'($urandom_range(20, 3)), 16'($urandom_range(4095)));
      run_random_traffic(120);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_alert(1'b1);
      rsp_hold_left = HOLD_OFF_CYCLES;
      repeat (16) begin
         send_sample(pick_distance(), 1'b0, pick_distance(), ($urandom_range(1) != 0));
         send_item(item_of(psg_pkg::FUNC_TICK));
      end
      wait_results_drained();
   endtask

   task automatic test_random_extremes();
      configure(16'd0, 16'hFFFF, 16'd255, 16'd1024, 16'd0, 16'd4095);
      run_random_traffic(120);
   endtask

   task automatic test_random_narrow_ramp();
      configure(16'd1000, 16'd1001, 16'd1, 16'd0, 16'd1024, 16'd0);
      run_random_traffic(60);
      quiesce_block();
      write_register(psg_pkg::CSR_CRUISE_SPEED, 16'($urandom_range(4095)));
      run_random_traffic(60);
   endtask

   // result side
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold_left--;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      speed_command_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_commands.size() == 0) begin
            report_mismatch("unexpected transfer, speed", 32'(rsp_speed_mm_s), 0);
         end else begin
            want = pending_commands.pop_front();
            if (rsp_speed_mm_s !== want.speed)
               report_mismatch("speed_mm_s", 32'(rsp_speed_mm_s), 32'(want.speed));
            if (rsp_visible_flag !== want.visible)
               report_mismatch("visible_flag", 32'(rsp_visible_flag), 32'(want.visible));
            if (rsp_front_distance_out !== want.front_mm)
               report_mismatch("front_distance_out", 32'(rsp_front_distance_out),
                               32'(want.front_mm));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0)) begin
         quiet_cycles = 0;
      end else if (!reset) begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_addr          = '0;
      csr_wdata         = '0;
      req_valid         = 1'b0;
      req_func          = psg_pkg::FUNC_ALERT;
      req_target_seen   = 1'b0;
      req_range_mm      = '0;
      req_range_invalid = 1'b0;
      req_range_max_mm  = '0;
      req_last_sample   = 1'b0;
      rsp_stall         = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 37;
      recv_idle_pct = 67;
      test_visibility_tracking();
      test_front_sector_and_ramp();
      test_slow_below_stop();
      test_unused_codes();
      test_random_moderate();
      send_idle_pct = 67;
      recv_idle_pct = 37;
      test_random_extremes();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_narrow_ramp();

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
